FILE: rtl/objtok_pkg.sv
package objtok_pkg;

   // field widths
   localparam int OFFSET_BITS = 24;
   localparam int LENGTH_BITS = 16;
   localparam int LINE_BITS   = 20;
   localparam int KIND_BITS   = 4;
   localparam int CHAR_BITS   = 8;

   localparam logic [OFFSET_BITS-1:0] OFFSET_MAX = '1;
   localparam logic [LENGTH_BITS-1:0] LENGTH_MAX = '1;
   localparam logic [LINE_BITS-1:0]   LINE_MAX   = '1;

   // token queue
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
   localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

   // special bytes
   localparam logic [CHAR_BITS-1:0] CHAR_NUL   = 8'h00;
   localparam logic [CHAR_BITS-1:0] CHAR_TAB   = 8'h09;
   localparam logic [CHAR_BITS-1:0] CHAR_LF    = 8'h0a;
   localparam logic [CHAR_BITS-1:0] CHAR_CR    = 8'h0d;
   localparam logic [CHAR_BITS-1:0] CHAR_SPACE = 8'h20;
   localparam logic [CHAR_BITS-1:0] CHAR_HASH  = 8'h23;
   localparam logic [CHAR_BITS-1:0] CHAR_PLUS  = 8'h2b;
   localparam logic [CHAR_BITS-1:0] CHAR_MINUS = 8'h2d;
   localparam logic [CHAR_BITS-1:0] CHAR_DOT   = 8'h2e;
   localparam logic [CHAR_BITS-1:0] CHAR_SLASH = 8'h2f;
   localparam logic [CHAR_BITS-1:0] CHAR_UP_E  = 8'h45;
   localparam logic [CHAR_BITS-1:0] CHAR_LO_E  = 8'h65;
   localparam logic [CHAR_BITS-1:0] CHAR_F     = 8'h66;
   localparam logic [CHAR_BITS-1:0] CHAR_G     = 8'h67;
   localparam logic [CHAR_BITS-1:0] CHAR_N     = 8'h6e;
   localparam logic [CHAR_BITS-1:0] CHAR_O     = 8'h6f;
   localparam logic [CHAR_BITS-1:0] CHAR_S     = 8'h73;
   localparam logic [CHAR_BITS-1:0] CHAR_T     = 8'h74;
   localparam logic [CHAR_BITS-1:0] CHAR_V     = 8'h76;

   typedef enum logic [KIND_BITS-1:0] {
      KIND_EOF        = 4'd0,
      KIND_ERROR      = 4'd1,
      KIND_COMMENT    = 4'd2,
      KIND_SLASH      = 4'd3,
      KIND_NEWLINE    = 4'd4,
      KIND_NUMBER     = 4'd5,
      KIND_IDENTIFIER = 4'd6,
      KIND_FACE       = 4'd7,
      KIND_GROUP      = 4'd8,
      KIND_OBJECT     = 4'd9,
      KIND_SMOOTH     = 4'd10,
      KIND_POSITION   = 4'd11,
      KIND_TEXCOORD   = 4'd12,
      KIND_NORMAL     = 4'd13
   } kind_type;

   typedef enum logic [2:0] {
      MODE_IDLE,
      MODE_COMMENT,
      MODE_IDENT,
      MODE_INT,
      MODE_FRAC,
      MODE_EXP_START,
      MODE_EXP_DIGITS
   } mode_type;

   typedef struct packed {
      kind_type               kind;
      logic [OFFSET_BITS-1:0] offset;
      logic [LENGTH_BITS-1:0] length;
      logic [LINE_BITS-1:0]   line;
      logic                   last;
   } token_type;

   function automatic logic is_letter(input logic [CHAR_BITS-1:0] c);
      return (c inside {[8'h61:8'h7a]}) || (c inside {[8'h41:8'h5a]});
   endfunction

   function automatic logic is_numeral(input logic [CHAR_BITS-1:0] c);
      return c inside {[8'h30:8'h39]};
   endfunction

endpackage

FILE: rtl/obj_text_tokenizer.sv
// channel   dir   ports                                  word
// req       in    req_valid, req_stall, req_char_code    one text byte
// rsp       out   rsp_valid, rsp_stall, rsp_token_*      one token
//
// one byte is taken per cycle while req_stall is low; its tokens (none, one or two) are written
// to a four-entry token queue in the same cycle and the head is shown on rsp
// req_stall is high while the queue has fewer than two free entries, so the
// output side, one token per cycle while rsp_stall is low, sets the sustained rate
// a zero byte flushes any pending token, queues an eof token and clears the
// scan state; synchronous reset empties the queue and clears the scan state
module obj_text_tokenizer (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [objtok_pkg::CHAR_BITS-1:0]    req_char_code,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [objtok_pkg::KIND_BITS-1:0]    rsp_token_kind,
   output logic [objtok_pkg::OFFSET_BITS-1:0]  rsp_token_offset,
   output logic [objtok_pkg::LENGTH_BITS-1:0]  rsp_token_length,
   output logic [objtok_pkg::LINE_BITS-1:0]    rsp_token_line,
   output logic                                rsp_last_of_run
);

   // scan state
   objtok_pkg::mode_type                 mode_ff, mode_in;
   logic [objtok_pkg::OFFSET_BITS-1:0]   pos_ff, pos_in;
   logic [objtok_pkg::OFFSET_BITS-1:0]   begin_ff, begin_in;
   logic [objtok_pkg::LINE_BITS-1:0]     line_ff, line_in;
   logic [objtok_pkg::LINE_BITS-1:0]     bline_ff, bline_in;
   logic [objtok_pkg::CHAR_BITS-1:0]     first_ff, first_in;
   logic [objtok_pkg::CHAR_BITS-1:0]     second_ff, second_in;
   logic [objtok_pkg::LENGTH_BITS-1:0]   run_ff, run_in;

   // token queue
   objtok_pkg::token_type                queue_mem [objtok_pkg::QUEUE_DEPTH];
   logic [objtok_pkg::QPTR_BITS-1:0]     head_ff, head_in;
   logic [objtok_pkg::QPTR_BITS-1:0]     tail_ff, tail_in;
   logic [objtok_pkg::QCNT_BITS-1:0]     count_ff, count_in;

   logic [objtok_pkg::CHAR_BITS-1:0]     c;
   logic                                 accept;
   logic                                 pop;
   logic                                 more;
   logic                                 cont;
   logic                                 flush;
   objtok_pkg::mode_type                 cont_mode;
   objtok_pkg::mode_type                 start_mode;
   logic                                 fresh_valid;
   objtok_pkg::kind_type                 flush_kind;
   objtok_pkg::kind_type                 ident_kind;
   objtok_pkg::token_type                flush_tok;
   objtok_pkg::token_type                fresh_tok;
   objtok_pkg::token_type                slot0;
   objtok_pkg::token_type                slot1;
   logic [1:0]                           push_n;
   logic [objtok_pkg::OFFSET_BITS-1:0]   pos_inc;
   logic [objtok_pkg::LINE_BITS-1:0]     line_inc;
   logic [objtok_pkg::LENGTH_BITS-1:0]   run_inc;

   assign c      = req_char_code;
   assign accept = req_valid && !req_stall;
   assign pop    = rsp_valid && !rsp_stall;

   // saturating counters
   assign pos_inc  = (pos_ff != objtok_pkg::OFFSET_MAX) ? pos_ff + 1'b1 : pos_ff;
   assign line_inc = (line_ff != objtok_pkg::LINE_MAX) ? line_ff + 1'b1 : line_ff;
   assign run_inc  = (run_ff != objtok_pkg::LENGTH_MAX) ? run_ff + 1'b1 : run_ff;

   // does the byte extend the pending token
   always_comb begin
      more      = 1'b0;
      cont_mode = mode_ff;
      case (mode_ff)
         objtok_pkg::MODE_COMMENT: begin
            more = (c != objtok_pkg::CHAR_LF) && (c != objtok_pkg::CHAR_NUL);
         end
         objtok_pkg::MODE_IDENT: begin
            more = objtok_pkg::is_letter(c) || objtok_pkg::is_numeral(c);
         end
         objtok_pkg::MODE_INT: begin
            if (objtok_pkg::is_numeral(c)) begin
               more = 1'b1;
            end else if (c == objtok_pkg::CHAR_DOT) begin
               more      = 1'b1;
               cont_mode = objtok_pkg::MODE_FRAC;
            end else if (c == objtok_pkg::CHAR_LO_E || c == objtok_pkg::CHAR_UP_E) begin
               more      = 1'b1;
               cont_mode = objtok_pkg::MODE_EXP_START;
            end
         end
         objtok_pkg::MODE_FRAC: begin
            if (objtok_pkg::is_numeral(c)) begin
               more = 1'b1;
            end else if (c == objtok_pkg::CHAR_LO_E || c == objtok_pkg::CHAR_UP_E) begin
               more      = 1'b1;
               cont_mode = objtok_pkg::MODE_EXP_START;
            end
         end
         objtok_pkg::MODE_EXP_START: begin
            if (objtok_pkg::is_numeral(c) || c == objtok_pkg::CHAR_PLUS ||
                c == objtok_pkg::CHAR_MINUS) begin
               more      = 1'b1;
               cont_mode = objtok_pkg::MODE_EXP_DIGITS;
            end
         end
         objtok_pkg::MODE_EXP_DIGITS: begin
            more = objtok_pkg::is_numeral(c);
         end
         default: begin
            more = 1'b0;
         end
      endcase
   end

   assign cont  = (mode_ff != objtok_pkg::MODE_IDLE) && more;
   assign flush = (mode_ff != objtok_pkg::MODE_IDLE) && !more;

   // mode a fresh byte opens
   always_comb begin
      if (c == objtok_pkg::CHAR_HASH) begin
         start_mode = objtok_pkg::MODE_COMMENT;
      end else if (objtok_pkg::is_letter(c)) begin
         start_mode = objtok_pkg::MODE_IDENT;
      end else if (c == objtok_pkg::CHAR_MINUS || objtok_pkg::is_numeral(c)) begin
         start_mode = objtok_pkg::MODE_INT;
      end else begin
         start_mode = objtok_pkg::MODE_IDLE;
      end
   end

   // next mode
   always_comb begin
      if (cont) begin
         mode_in = cont_mode;
      end else if (c == objtok_pkg::CHAR_NUL) begin
         mode_in = objtok_pkg::MODE_IDLE;
      end else begin
         mode_in = start_mode;
      end
   end

   // keyword lookup for a finished identifier
   always_comb begin
      ident_kind = objtok_pkg::KIND_IDENTIFIER;
      if (run_ff == objtok_pkg::LENGTH_BITS'(1)) begin
         case (first_ff)
            objtok_pkg::CHAR_F: ident_kind = objtok_pkg::KIND_FACE;
            objtok_pkg::CHAR_G: ident_kind = objtok_pkg::KIND_GROUP;
            objtok_pkg::CHAR_O: ident_kind = objtok_pkg::KIND_OBJECT;
            objtok_pkg::CHAR_S: ident_kind = objtok_pkg::KIND_SMOOTH;
            objtok_pkg::CHAR_V: ident_kind = objtok_pkg::KIND_POSITION;
            default:            ident_kind = objtok_pkg::KIND_IDENTIFIER;
         endcase
      end else if (run_ff == objtok_pkg::LENGTH_BITS'(2) && first_ff == objtok_pkg::CHAR_V) begin
         if (second_ff == objtok_pkg::CHAR_T) begin
            ident_kind = objtok_pkg::KIND_TEXCOORD;
         end else if (second_ff == objtok_pkg::CHAR_N) begin
            ident_kind = objtok_pkg::KIND_NORMAL;
         end
      end
   end

   // flushed token kind
   always_comb begin
      case (mode_ff)
         objtok_pkg::MODE_COMMENT: flush_kind = objtok_pkg::KIND_COMMENT;
         objtok_pkg::MODE_IDENT:   flush_kind = ident_kind;
         default:                  flush_kind = objtok_pkg::KIND_NUMBER;
      endcase
   end

   // tokens caused by this byte
   always_comb begin
      flush_tok.kind   = flush_kind;
      flush_tok.offset = begin_ff;
      flush_tok.length = run_ff;
      flush_tok.line   = bline_ff;
      flush_tok.last   = 1'b1;

      fresh_tok.offset = pos_ff;
      fresh_tok.length = objtok_pkg::LENGTH_BITS'(1);
      fresh_tok.line   = line_ff;
      fresh_tok.last   = 1'b1;
      fresh_tok.kind   = objtok_pkg::KIND_ERROR;
      fresh_valid      = 1'b0;
      if (!cont) begin
         if (c == objtok_pkg::CHAR_NUL) begin
            fresh_tok.kind   = objtok_pkg::KIND_EOF;
            fresh_tok.length = '0;
            fresh_valid      = 1'b1;
         end else if (c == objtok_pkg::CHAR_SLASH) begin
            fresh_tok.kind = objtok_pkg::KIND_SLASH;
            fresh_valid    = 1'b1;
         end else if (c == objtok_pkg::CHAR_LF) begin
            fresh_tok.kind = objtok_pkg::KIND_NEWLINE;
            fresh_valid    = 1'b1;
         end else if (c == objtok_pkg::CHAR_SPACE || c == objtok_pkg::CHAR_TAB ||
                      c == objtok_pkg::CHAR_CR ||
                      start_mode != objtok_pkg::MODE_IDLE) begin
            fresh_valid = 1'b0;
         end else begin
            fresh_tok.kind = objtok_pkg::KIND_ERROR;
            fresh_valid    = 1'b1;
         end
      end

      if (flush) begin
         slot0      = flush_tok;
         slot0.last = !fresh_valid;
      end else begin
         slot0 = fresh_tok;
      end
      slot1  = fresh_tok;
      push_n = {1'b0, flush} + {1'b0, fresh_valid};
   end

   // next scan registers
   always_comb begin
      pos_in    = pos_ff;
      begin_in  = begin_ff;
      line_in   = line_ff;
      bline_in  = bline_ff;
      first_in  = first_ff;
      second_in = second_ff;
      run_in    = run_ff;
      if (cont) begin
         if (mode_ff == objtok_pkg::MODE_IDENT && run_ff == objtok_pkg::LENGTH_BITS'(1)) begin
            second_in = c;
         end
         run_in = run_inc;
         pos_in = pos_inc;
      end else if (c == objtok_pkg::CHAR_NUL) begin
         pos_in    = '0;
         begin_in  = '0;
         line_in   = '0;
         bline_in  = '0;
         first_in  = '0;
         second_in = '0;
         run_in    = '0;
      end else begin
         if (start_mode != objtok_pkg::MODE_IDLE) begin
            begin_in = pos_ff;
            bline_in = line_ff;
            run_in   = objtok_pkg::LENGTH_BITS'(1);
         end else begin
            run_in = '0;
         end
         if (start_mode == objtok_pkg::MODE_IDENT) begin
            first_in  = c;
            second_in = '0;
         end
         if (c == objtok_pkg::CHAR_LF) begin
            line_in = line_inc;
         end
         pos_in = pos_inc;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= objtok_pkg::MODE_IDLE;
         pos_ff    <= '0;
         begin_ff  <= '0;
         line_ff   <= '0;
         bline_ff  <= '0;
         first_ff  <= '0;
         second_ff <= '0;
         run_ff    <= '0;
      end else if (accept) begin
         mode_ff   <= mode_in;
         pos_ff    <= pos_in;
         begin_ff  <= begin_in;
         line_ff   <= line_in;
         bline_ff  <= bline_in;
         first_ff  <= first_in;
         second_ff <= second_in;
         run_ff    <= run_in;
      end
   end

   // queue pointers
   always_comb begin
      head_in  = pop ? head_ff + 1'b1 : head_ff;
      tail_in  = accept ? tail_ff + objtok_pkg::QPTR_BITS'(push_n) : tail_ff;
      count_in = count_ff + (accept ? objtok_pkg::QCNT_BITS'(push_n) : '0)
                 - objtok_pkg::QCNT_BITS'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         tail_ff  <= '0;
         count_ff <= '0;
      end else begin
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         count_ff <= count_in;
      end
   end

   // queue storage
   always_ff @(posedge clock) begin
      if (accept && push_n != 2'd0) begin
         queue_mem[tail_ff] <= slot0;
      end
      if (accept && push_n == 2'd2) begin
         queue_mem[tail_ff + 1'b1] <= slot1;
      end
   end

   // handshakes and result word
   assign req_stall        = count_ff > objtok_pkg::QCNT_BITS'(objtok_pkg::QUEUE_DEPTH - 2);
   assign rsp_valid        = count_ff != '0;
   assign rsp_token_kind   = queue_mem[head_ff].kind;
   assign rsp_token_offset = queue_mem[head_ff].offset;
   assign rsp_token_length = queue_mem[head_ff].length;
   assign rsp_token_line   = queue_mem[head_ff].line;
   assign rsp_last_of_run  = queue_mem[head_ff].last;

endmodule

FILE: rtl/objtok_checker.sv
module objtok_props (
   input logic                                clock,
   input logic                                reset,
   input logic                                req_valid,
   input logic                                req_stall,
   input logic [objtok_pkg::CHAR_BITS-1:0]    req_char_code,
   input logic                                rsp_valid,
   input logic                                rsp_stall,
   input logic [objtok_pkg::KIND_BITS-1:0]    rsp_token_kind,
   input logic [objtok_pkg::OFFSET_BITS-1:0]  rsp_token_offset,
   input logic [objtok_pkg::LENGTH_BITS-1:0]  rsp_token_length,
   input logic [objtok_pkg::LINE_BITS-1:0]    rsp_token_line,
   input logic                                rsp_last_of_run
);

   // a stalled token holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_token_kind) &&
      $stable(rsp_token_offset) && $stable(rsp_token_length) &&
      $stable(rsp_token_line) && $stable(rsp_last_of_run))
      else $error("stalled token changed");

   // an end-of-text byte always leaves a token to deliver
   a_eof_queued: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && req_char_code == objtok_pkg::CHAR_NUL |=> rsp_valid)
      else $error("no token after end of text");

   // eof token is empty and closes its run
   a_eof_shape: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_token_kind == objtok_pkg::KIND_EOF |->
      rsp_token_length == '0 && rsp_last_of_run)
      else $error("bad eof token");

   // single-byte tokens have length one
   a_single_len: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_token_kind == objtok_pkg::KIND_SLASH ||
      rsp_token_kind == objtok_pkg::KIND_NEWLINE ||
      rsp_token_kind == objtok_pkg::KIND_ERROR) |->
      rsp_token_length == objtok_pkg::LENGTH_BITS'(1) && rsp_last_of_run)
      else $error("bad single-byte token");

   // reset empties the queue
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("token shown after reset");

endmodule

bind obj_text_tokenizer objtok_props u_objtok_props (.*);
